// ===== hw/rtl/tss_pkg.sv =====
// Shared types, constants and Q16.32 arithmetic helpers for the tridiagonal solver.
// No dependencies; used by every module of the block.
package tss_pkg;

    typedef logic signed [47:0] t_fx;

    localparam t_fx FX_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_fx FX_MIN = 48'sh8000_0000_0000;
    localparam t_fx FX_ONE = 48'sh0001_0000_0000;
    localparam t_fx FX_ZERO = 48'sh0000_0000_0000;

    // one input beat: a row of the system
    typedef struct packed {
        t_fx  lower_coef;
        t_fx  diag_coef;
        t_fx  upper_coef;
        t_fx  rhs_value;
        logic last_row;
    } t_row;

    // one output beat: a solution entry
    typedef struct packed {
        t_fx  solution_value;
        logic last_value;
        logic solve_error;
    } t_res;

    // stored coefficients of one row
    typedef struct packed {
        t_fx lower;
        t_fx diag;
        t_fx upper;
        t_fx rhs;
    } t_coef;

    // request to and response from the shared multiply / divide units
    typedef struct packed {
        logic start;
        t_fx  a;
        t_fx  b;
    } t_op_req;

    typedef struct packed {
        logic done;
        t_fx  res;
        logic fault;
    } t_op_rsp;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_INIT3,
        S_F_NEXT,
        S_F_RDU,
        S_F_CDIV,
        S_F_CW,
        S_F_T2,
        S_F_T1,
        S_F_X1,
        S_F_X2,
        S_F_Q1,
        S_F_Q2,
        S_B_RD,
        S_B_X,
        S_B_X2,
        S_B_Q2,
        S_B_NEXT,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_O_RD,
        S_O_CALC,
        S_O_MUL,
        S_O_EMIT
    } t_state;

    // saturate a 49-bit two's complement sum to 48 bits
    function automatic t_fx fx_sat49(logic [48:0] s);
        if (s[48] != s[47]) begin
            return s[48] ? FX_MIN : FX_MAX;
        end
        return t_fx'(s[47:0]);
    endfunction

    function automatic t_fx fx_add(t_fx a, t_fx b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        return fx_sat49(s);
    endfunction

    function automatic t_fx fx_sub(t_fx a, t_fx b);
        logic [48:0] s;
        s = {a[47], a} - {b[47], b};
        return fx_sat49(s);
    endfunction

    function automatic t_fx fx_neg(t_fx a);
        return fx_sub(FX_ZERO, a);
    endfunction

    // magnitude, the most negative value maps to 2^47
    function automatic logic [47:0] fx_mag(t_fx a);
        return a[47] ? (~a + 48'd1) : a;
    endfunction

    // signed value from a magnitude and sign, saturated
    function automatic t_fx fx_from_mag(logic [79:0] m, logic neg);
        if (neg) begin
            if (m >= 80'h8000_0000_0000) begin
                return FX_MIN;
            end
            return t_fx'(~m[47:0] + 48'd1);
        end
        if (m > 80'h7FFF_FFFF_FFFF) begin
            return FX_MAX;
        end
        return t_fx'(m[47:0]);
    endfunction

endpackage

// ===== hw/rtl/tss_front.sv =====
// Input side of the solver: two-entry row queue between the input port and the solve engine.
// Depends on tss_pkg for the row type.
module tss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tss_pkg::t_row i_in_data,
    output logic          o_q_valid,
    output tss_pkg::t_row o_q_row,
    input  logic          i_q_pop
);

    tss_pkg::t_row r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_row    = r_buf[r_rp];

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    // row storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_in_data;
        end
    end

endmodule

// ===== hw/rtl/tss_mul.sv =====
// Q16.32 multiplier: one 32x32 unsigned multiplier over four partial products.
// Depends on tss_pkg for the operand types and saturation helpers.
module tss_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tss_pkg::t_op_req i_req,
    output tss_pkg::t_op_rsp o_rsp
);

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [47:0] r_ma;
    logic [47:0] r_mb;
    logic        r_neg;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic        r_ovf;
    logic        r_done;
    tss_pkg::t_fx r_res;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;

    // partial product select: lo*lo, hi*lo, lo*hi, hi*hi
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin op_a = r_ma[31:0];           op_b = r_mb[31:0];           end
            2'd1: begin op_a = {16'd0, r_ma[47:32]}; op_b = r_mb[31:0];           end
            2'd2: begin op_a = r_ma[31:0];           op_b = {16'd0, r_mb[47:32]}; end
            default: begin
                op_a = {16'd0, r_ma[47:32]};
                op_b = {16'd0, r_mb[47:32]};
            end
        endcase
    end

    assign prod = op_a * op_b;

    // sequencing: products in counts 0..3, each accumulated from the product register, then the result is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_ma   <= tss_pkg::fx_mag(i_req.a);
                r_mb   <= tss_pkg::fx_mag(i_req.b);
                r_neg  <= i_req.a[47] ^ i_req.b[47];
                r_acc  <= 64'd0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt <= 3'd3) begin
                    r_prod <= prod;
                end
                unique case (r_cnt)
                    3'd1: r_acc <= r_acc + {32'd0, r_prod[63:32]};
                    3'd2, 3'd3: r_acc <= r_acc + r_prod;
                    3'd4: begin
                        if (r_prod >= 64'h8000) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_acc <= r_acc + {r_prod[31:0], 32'd0};
                        end
                    end
                    3'd5: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_ovf) begin
                            r_res <= r_neg ? tss_pkg::FX_MIN : tss_pkg::FX_MAX;
                        end else begin
                            r_res <= tss_pkg::fx_from_mag({16'd0, r_acc}, r_neg);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.res   = r_res;
    assign o_rsp.fault = 1'b0;

endmodule

// ===== hw/rtl/tss_div.sv =====
// Q16.32 divider: restoring division, one quotient bit per cycle over 80 bits.
// Depends on tss_pkg for the operand types and saturation helpers.
module tss_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tss_pkg::t_op_req i_req,
    output tss_pkg::t_op_rsp o_rsp
);

    localparam logic [6:0] NBITS = 7'd80;

    logic         r_busy;
    logic [6:0]   r_cnt;
    logic [79:0]  r_dsh;
    logic [47:0]  r_mb;
    logic [48:0]  r_rem;
    logic [79:0]  r_quo;
    logic         r_neg;
    logic         r_done;
    logic         r_fault;
    tss_pkg::t_fx r_res;
    logic [48:0]  rem_sh;
    logic         fits;

    assign rem_sh = {r_rem[47:0], r_dsh[79]};
    assign fits   = (rem_sh >= {1'b0, r_mb});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_req.a[47] ^ i_req.b[47];
                if (i_req.b == tss_pkg::FX_ZERO) begin
                    // zero divisor: quotient 0, flagged
                    r_done  <= 1'b1;
                    r_fault <= 1'b1;
                    r_res   <= tss_pkg::FX_ZERO;
                end else begin
                    r_busy  <= 1'b1;
                    r_fault <= 1'b0;
                    r_cnt   <= 7'd0;
                    r_dsh   <= {tss_pkg::fx_mag(i_req.a), 32'd0};
                    r_mb    <= tss_pkg::fx_mag(i_req.b);
                    r_rem   <= 49'd0;
                    r_quo   <= 80'd0;
                end
            end else if (r_busy) begin
                if (r_cnt == NBITS) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= tss_pkg::fx_from_mag(r_quo, r_neg);
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                    r_dsh <= {r_dsh[78:0], 1'b0};
                    r_rem <= fits ? (rem_sh - {1'b0, r_mb}) : rem_sh;
                    r_quo <= {r_quo[78:0], fits};
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.res   = r_res;
    assign o_rsp.fault = r_fault;

endmodule

// ===== hw/rtl/tss_back.sv =====
// Solve engine: row stores, forward/back sweep sequencer, cyclic correction, result output.
// Depends on tss_pkg, tss_mul and tss_div.
module tss_back #(
    parameter int MAX_ROWS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tss_pkg::t_row i_q_row,
    output logic          o_q_pop,
    input  logic          i_cyclic,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tss_pkg::t_res o_out_data
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    tss_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_mlast, n_mlast;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_cyc, n_cyc;
    logic            r_zero, n_zero;
    logic            r_err, n_err;
    tss_pkg::t_fx    r_t, n_t;
    tss_pkg::t_fx    r_x, n_x;
    tss_pkg::t_fx    r_q, n_q;
    tss_pkg::t_fx    r_c, n_c;
    tss_pkg::t_fx    r_xlast, n_xlast;
    tss_pkg::t_fx    r_qlast, n_qlast;
    tss_pkg::t_fx    r_l0, n_l0;
    tss_pkg::t_fx    r_num, n_num;
    tss_pkg::t_fx    r_val, n_val;
    tss_pkg::t_fx    r_y, n_y;

    // row stores and solve vectors
    tss_pkg::t_coef  row_mem [MAX_ROWS];
    tss_pkg::t_fx    c_mem [MAX_ROWS];
    tss_pkg::t_fx    x_mem [MAX_ROWS];
    tss_pkg::t_fx    q_mem [MAX_ROWS];
    tss_pkg::t_coef  rd_row;
    tss_pkg::t_fx    rd_c;
    tss_pkg::t_fx    rd_x;
    tss_pkg::t_fx    rd_q;

    logic            row_we;
    logic            c_we;
    logic            x_we;
    logic            q_we;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   c_waddr;
    tss_pkg::t_fx    wd;
    tss_pkg::t_fx    t0;
    logic            cyc_last;
    logic            room;

    tss_pkg::t_op_req mul_req, div_req;
    tss_pkg::t_op_rsp mul_rsp, div_rsp;

    tss_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    tss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign cyc_last = r_cyc && (r_idx == r_mlast);
    assign room     = (r_cnt < CW'(MAX_ROWS));
    assign t0       = r_cyc ? tss_pkg::fx_sub(rd_row.diag, tss_pkg::FX_ONE) : rd_row.diag;

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[r_cnt[AW-1:0]] <= '{lower: i_q_row.lower_coef, diag: i_q_row.diag_coef,
                                        upper: i_q_row.upper_coef, rhs: i_q_row.rhs_value};
        end
        rd_row <= row_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            c_mem[c_waddr] <= wd;
        end
        rd_c <= c_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[r_idx] <= wd;
        end
        rd_x <= x_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[r_idx] <= wd;
        end
        rd_q <= q_mem[raddr];
    end

    // sequencer: next state, datapath updates, unit requests
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mlast = r_mlast;
        n_idx   = r_idx;
        n_cyc   = r_cyc;
        n_zero  = r_zero;
        n_err   = r_err | (div_rsp.done & div_rsp.fault);
        n_t     = r_t;
        n_x     = r_x;
        n_q     = r_q;
        n_c     = r_c;
        n_xlast = r_xlast;
        n_qlast = r_qlast;
        n_l0    = r_l0;
        n_num   = r_num;
        n_val   = r_val;
        n_y     = r_y;
        mul_req = '0;
        div_req = '0;
        row_we  = 1'b0;
        c_we    = 1'b0;
        x_we    = 1'b0;
        q_we    = 1'b0;
        raddr   = r_idx;
        c_waddr = r_idx - AW'(1);
        wd      = div_rsp.res;
        o_q_pop = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            // take rows, dropping any beyond MAX_ROWS; the last one starts the solve, or flags a one-row cyclic system
            tss_pkg::S_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (room) begin
                        row_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                    end
                    if (i_q_row.last_row) begin
                        n_cnt   = '0;
                        n_mlast = room ? r_cnt[AW-1:0] : AW'(MAX_ROWS - 1);
                        n_cyc   = i_cyclic;
                        n_err   = 1'b0;
                        n_idx   = '0;
                        if (i_cyclic && (n_mlast == '0)) begin
                            n_err   = 1'b1;
                            n_zero  = 1'b1;
                            n_state = tss_pkg::S_O_RD;
                        end else begin
                            n_zero  = 1'b0;
                            n_state = tss_pkg::S_INIT0;
                        end
                    end
                end
            end
            // first row
            tss_pkg::S_INIT0: n_state = tss_pkg::S_INIT1;
            tss_pkg::S_INIT1: begin
                n_t = t0;
                n_l0 = rd_row.lower;
                div_req = '{start: 1'b1, a: rd_row.rhs, b: t0};
                n_state = tss_pkg::S_INIT2;
            end
            tss_pkg::S_INIT2: begin
                if (div_rsp.done) begin
                    n_x  = div_rsp.res;
                    x_we = 1'b1;
                    if (r_cyc) begin
                        div_req = '{start: 1'b1, a: tss_pkg::FX_ONE, b: r_t};
                        n_state = tss_pkg::S_INIT3;
                    end else begin
                        n_state = tss_pkg::S_F_NEXT;
                    end
                end
            end
            tss_pkg::S_INIT3: begin
                if (div_rsp.done) begin
                    n_q  = div_rsp.res;
                    q_we = 1'b1;
                    n_state = tss_pkg::S_F_NEXT;
                end
            end
            // forward elimination, one row per pass
            tss_pkg::S_F_NEXT: begin
                if (r_idx == r_mlast) begin
                    if (r_mlast == '0) begin
                        n_idx   = '0;
                        n_state = tss_pkg::S_O_RD;
                    end else begin
                        n_xlast = r_x;
                        n_qlast = r_q;
                        n_idx   = r_mlast - AW'(1);
                        n_state = tss_pkg::S_B_RD;
                    end
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = tss_pkg::S_F_RDU;
                end
            end
            tss_pkg::S_F_RDU: begin
                raddr   = r_idx - AW'(1);
                n_state = tss_pkg::S_F_CDIV;
            end
            tss_pkg::S_F_CDIV: begin
                div_req = '{start: 1'b1, a: rd_row.upper, b: r_t};
                n_state = tss_pkg::S_F_CW;
            end
            tss_pkg::S_F_CW: begin
                if (div_rsp.done) begin
                    n_c  = div_rsp.res;
                    c_we = 1'b1;
                    if (cyc_last) begin
                        mul_req = '{start: 1'b1, a: rd_row.upper, b: r_l0};
                        n_state = tss_pkg::S_F_T2;
                    end else begin
                        mul_req = '{start: 1'b1, a: rd_row.lower, b: div_rsp.res};
                        n_state = tss_pkg::S_F_T1;
                    end
                end
            end
            tss_pkg::S_F_T2: begin
                if (mul_rsp.done) begin
                    n_t = tss_pkg::fx_sub(rd_row.diag, mul_rsp.res);
                    mul_req = '{start: 1'b1, a: rd_row.lower, b: r_c};
                    n_state = tss_pkg::S_F_T1;
                end
            end
            tss_pkg::S_F_T1: begin
                if (mul_rsp.done) begin
                    n_t = tss_pkg::fx_sub(cyc_last ? r_t : rd_row.diag, mul_rsp.res);
                    mul_req = '{start: 1'b1, a: rd_row.lower, b: r_x};
                    n_state = tss_pkg::S_F_X1;
                end
            end
            tss_pkg::S_F_X1: begin
                if (mul_rsp.done) begin
                    div_req = '{start: 1'b1, a: tss_pkg::fx_sub(rd_row.rhs, mul_rsp.res),
                                b: r_t};
                    n_state = tss_pkg::S_F_X2;
                end
            end
            tss_pkg::S_F_X2: begin
                if (div_rsp.done) begin
                    n_x  = div_rsp.res;
                    x_we = 1'b1;
                    if (r_cyc) begin
                        mul_req = '{start: 1'b1, a: rd_row.lower, b: r_q};
                        n_state = tss_pkg::S_F_Q1;
                    end else begin
                        n_state = tss_pkg::S_F_NEXT;
                    end
                end
            end
            tss_pkg::S_F_Q1: begin
                if (mul_rsp.done) begin
                    div_req = '{start: 1'b1,
                                a: cyc_last ? tss_pkg::fx_sub(rd_row.upper, mul_rsp.res)
                                            : tss_pkg::fx_neg(mul_rsp.res),
                                b: r_t};
                    n_state = tss_pkg::S_F_Q2;
                end
            end
            tss_pkg::S_F_Q2: begin
                if (div_rsp.done) begin
                    n_q  = div_rsp.res;
                    q_we = 1'b1;
                    n_state = tss_pkg::S_F_NEXT;
                end
            end
            // back substitution, from the row before the last down to row 0
            tss_pkg::S_B_RD: n_state = tss_pkg::S_B_X;
            tss_pkg::S_B_X: begin
                mul_req = '{start: 1'b1, a: rd_c, b: r_x};
                n_state = tss_pkg::S_B_X2;
            end
            tss_pkg::S_B_X2: begin
                if (mul_rsp.done) begin
                    wd   = tss_pkg::fx_sub(rd_x, mul_rsp.res);
                    n_x  = wd;
                    x_we = 1'b1;
                    if (r_cyc) begin
                        mul_req = '{start: 1'b1, a: rd_c, b: r_q};
                        n_state = tss_pkg::S_B_Q2;
                    end else begin
                        n_state = tss_pkg::S_B_NEXT;
                    end
                end
            end
            tss_pkg::S_B_Q2: begin
                if (mul_rsp.done) begin
                    wd   = tss_pkg::fx_sub(rd_q, mul_rsp.res);
                    n_q  = wd;
                    q_we = 1'b1;
                    n_state = tss_pkg::S_B_NEXT;
                end
            end
            tss_pkg::S_B_NEXT: begin
                if (r_idx == '0) begin
                    n_state = r_cyc ? tss_pkg::S_C0 : tss_pkg::S_O_RD;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = tss_pkg::S_B_RD;
                end
            end
            // corner correction factor
            tss_pkg::S_C0: begin
                mul_req = '{start: 1'b1, a: r_l0, b: r_xlast};
                n_state = tss_pkg::S_C1;
            end
            tss_pkg::S_C1: begin
                if (mul_rsp.done) begin
                    n_num   = tss_pkg::fx_add(r_x, mul_rsp.res);
                    mul_req = '{start: 1'b1, a: r_l0, b: r_qlast};
                    n_state = tss_pkg::S_C2;
                end
            end
            tss_pkg::S_C2: begin
                if (mul_rsp.done) begin
                    div_req = '{start: 1'b1, a: r_num,
                                b: tss_pkg::fx_add(tss_pkg::fx_add(tss_pkg::FX_ONE, r_q),
                                                   mul_rsp.res)};
                    n_state = tss_pkg::S_C3;
                end
            end
            tss_pkg::S_C3: begin
                if (div_rsp.done) begin
                    n_val   = div_rsp.res;
                    n_idx   = '0;
                    n_state = tss_pkg::S_O_RD;
                end
            end
            // output pass, applies the correction in cyclic mode and emits zeros for a flagged one-row system
            tss_pkg::S_O_RD: n_state = tss_pkg::S_O_CALC;
            tss_pkg::S_O_CALC: begin
                if (r_zero) begin
                    n_y     = tss_pkg::FX_ZERO;
                    n_state = tss_pkg::S_O_EMIT;
                end else if (r_cyc) begin
                    mul_req = '{start: 1'b1, a: rd_q, b: r_val};
                    n_state = tss_pkg::S_O_MUL;
                end else begin
                    n_y     = rd_x;
                    n_state = tss_pkg::S_O_EMIT;
                end
            end
            tss_pkg::S_O_MUL: begin
                if (mul_rsp.done) begin
                    n_y     = tss_pkg::fx_sub(rd_x, mul_rsp.res);
                    n_state = tss_pkg::S_O_EMIT;
                end
            end
            tss_pkg::S_O_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == r_mlast) begin
                        n_state = tss_pkg::S_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = tss_pkg::S_O_RD;
                    end
                end
            end
            default: n_state = tss_pkg::S_LOAD;
        endcase
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tss_pkg::S_LOAD;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_mlast <= '0;
            r_cyc   <= 1'b0;
            r_zero  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_mlast <= n_mlast;
            r_cyc   <= n_cyc;
            r_zero  <= n_zero;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_x     <= n_x;
        r_q     <= n_q;
        r_c     <= n_c;
        r_xlast <= n_xlast;
        r_qlast <= n_qlast;
        r_l0    <= n_l0;
        r_num   <= n_num;
        r_val   <= n_val;
        r_y     <= n_y;
    end

    assign o_out_data.solution_value = r_y;
    assign o_out_data.last_value     = (r_idx == r_mlast);
    assign o_out_data.solve_error    = r_err;

endmodule

// ===== hw/rtl/tridiagonal_system_solver.sv =====
// Tridiagonal solver (plain or periodic), signed Q16.32. Rows enter at one beat per cycle
// while the two-entry queue has room; the solve starts on the last row. The bit-serial
// divider sets the pace of the solve, and results follow it one beat at a time.
// Synchronous active-low reset clears control state and the mode register; stores need no
// clearing pass, so rows are taken from the first cycle after reset.
module tridiagonal_system_solver #(
    parameter int MAX_ROWS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tss_pkg::t_row i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tss_pkg::t_res o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    logic          r_cyclic;
    logic          q_valid;
    logic          q_pop;
    tss_pkg::t_row q_row;

    // mode register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyclic <= 1'b0;
        end else if (i_cfg_valid) begin
            r_cyclic <= i_cfg_data;
        end
    end

    tss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_row    (q_row),
        .i_q_pop    (q_pop)
    );

    tss_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_row     (q_row),
        .o_q_pop     (q_pop),
        .i_cyclic    (r_cyclic),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // rows are only taken from a non-empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("row popped from empty queue");

    // no row intake while results are being delivered
    a_no_pop_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !q_pop)
        else $error("row taken during result delivery");

    // the final result beat returns the engine to row intake
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_value) |=> !o_out_valid)
        else $error("result beat after final entry");

endmodule
